// ===== rtl/stack_with_remove_by_value_macros.svh =====
// ----------------------------------------------------------------------------
// stack_with_remove_by_value_macros
// Assertion helpers shared by the stack controller and datapath.
// All checks are clocked on the rising edge and disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_REMOVE_BY_VALUE_MACROS_SVH
`define STACK_WITH_REMOVE_BY_VALUE_MACROS_SVH

// Same-cycle implication: when pre holds, post must hold in that cycle.
`define SWR_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication: when pre holds, post must hold in the cycle after.
`define SWR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/swr_pkg.sv =====
// ----------------------------------------------------------------------------
// swr_pkg
// Shared codes and controller/datapath command and status types for the
// stack with remove-by-value.
// ----------------------------------------------------------------------------
package swr_pkg;

  // Operation codes carried in the opcode field
  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Field widths fixed by the interface
  localparam int ID_W     = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the search key and the per-entry match vector
    logic commit;   // apply the push or the removal
    logic push;     // operation being committed is a push
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;     // every entry holds data
    logic found;    // latched search hit at least one stored entry
  } dp_sts_t;

endpackage

// ===== rtl/swr_in_if.sv =====
// ----------------------------------------------------------------------------
// swr_in_if
// Command channel: valid/ready handshake carrying an opcode and an identifier.
// ----------------------------------------------------------------------------
interface swr_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [swr_pkg::ID_W-1:0]  car_id;

  modport source (output valid, output opcode, output car_id, input ready);
  modport sink   (input valid, input opcode, input car_id, output ready);
endinterface

// ===== rtl/swr_out_if.sv =====
// ----------------------------------------------------------------------------
// swr_out_if
// Result channel: valid/ready handshake carrying a status and entry count.
// ----------------------------------------------------------------------------
interface swr_out_if;
  logic                          valid;
  logic                          ready;
  logic [swr_pkg::STATUS_W-1:0]  status;
  logic [swr_pkg::COUNT_W-1:0]   entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// ===== rtl/swr_datapath.sv =====
// ----------------------------------------------------------------------------
// swr_datapath
// Entry cells, fill counter and the per-cell compare and shift logic. Each
// cell compares itself against the key in the capture cycle; in the commit
// cycle every cell at or above the topmost hit takes its upper neighbor.
// ----------------------------------------------------------------------------
`include "stack_with_remove_by_value_macros.svh"

module swr_datapath #(
  parameter int DEPTH = 32,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  swr_pkg::dp_cmd_t          cmd,
  input  logic [swr_pkg::ID_W-1:0]  car_id,
  output swr_pkg::dp_sts_t          sts,
  output logic [CW-1:0]             fill
);

  logic [swr_pkg::ID_W-1:0] cells_r [DEPTH];
  logic [swr_pkg::ID_W-1:0] id_r;
  logic [DEPTH-1:0]         match_r;
  logic [DEPTH-1:0]         match_nxt;
  logic [DEPTH-1:0]         above;
  logic [CW-1:0]            fill_r;
  logic [CW-1:0]            fill_nxt;
  logic                     full;
  logic                     found;

  // Per-cell compare against the incoming key, limited to occupied cells
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      match_nxt[k] = (cells_r[k] == car_id) && (CW'(k) < fill_r);
    end
  end

  // Key and match vector latched when a word is accepted
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      id_r    <= car_id;
      match_r <= match_nxt;
    end
  end

  // above[k]: some hit sits strictly above cell k (log-step suffix OR)
  always_comb begin
    above = match_r >> 1;
    for (int s = 1; s < DEPTH; s = s * 2) begin
      above = above | (above >> s);
    end
  end

  assign full  = (fill_r == CW'(DEPTH));
  assign found = |match_r;

  // Cell updates: write on push, shift down above the removed entry
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k < DEPTH - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.commit) begin
          if (cmd.push && !full && (fill_r == CW'(k))) begin
            cells_r[k] <= id_r;
          end else if (!cmd.push && found && !above[k]) begin
            cells_r[k] <= cells_r[k+1];
          end
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (cmd.commit && cmd.push && !full && (fill_r == CW'(k))) begin
          cells_r[k] <= id_r;
        end
      end
    end
  end

  // Fill counter
  always_comb begin
    fill_nxt = fill_r;
    if (cmd.commit) begin
      if (cmd.push && !full) begin
        fill_nxt = fill_r + 1'b1;
      end else if (!cmd.push && found) begin
        fill_nxt = fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign sts.full  = full;
  assign sts.found = found;
  assign fill      = fill_r;

  // Checks
  `SWR_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_r <= CW'(DEPTH), "fill above depth")
  `SWR_ASSERT_NEXT(a_push_grows, clk, rst_n, cmd.commit && cmd.push && !full, fill_r == $past(fill_r) + 1'b1, "push did not grow fill")
  `SWR_ASSERT_NOW(a_hit_needs_data, clk, rst_n, cmd.commit && !cmd.push && found, fill_r != '0, "hit recorded in empty store")

endmodule

// ===== rtl/swr_ctrl.sv =====
// ----------------------------------------------------------------------------
// swr_ctrl
// Two-state sequencer: accept and compare, then commit into the result
// register once it is free. Owns the handshakes and the status code.
// ----------------------------------------------------------------------------
`include "stack_with_remove_by_value_macros.svh"

module swr_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_opcode,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swr_pkg::STATUS_W-1:0]  out_status,
  output swr_pkg::dp_cmd_t              cmd,
  input  swr_pkg::dp_sts_t              sts
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_COMMIT = 1'b1;

  logic                         state_r;
  logic                         state_nxt;
  logic                         op_r;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [swr_pkg::STATUS_W-1:0] status_r;
  logic [swr_pkg::STATUS_W-1:0] status_nxt;
  logic                         accept;
  logic                         commit;

  // Handshake and command decode
  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign commit      = (state_r == S_COMMIT) && (!out_valid_r || out_ready);
  assign cmd.capture = accept;
  assign cmd.commit  = commit;
  assign cmd.push    = (op_r == swr_pkg::OP_PUSH);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_COMMIT;
      S_COMMIT: if (commit) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Result word
  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (commit) begin
      out_valid_nxt = 1'b1;
      if (op_r == swr_pkg::OP_PUSH) begin
        status_nxt = sts.full ? swr_pkg::ST_FULL : swr_pkg::ST_DONE;
      end else begin
        status_nxt = sts.found ? swr_pkg::ST_DONE : swr_pkg::ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (accept) begin
      op_r <= in_opcode;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;

  // Checks
  `SWR_ASSERT_NEXT(a_accept_to_commit, clk, rst_n, accept, state_r == S_COMMIT, "accept did not enter commit")
  `SWR_ASSERT_NOW(a_commit_slot_free, clk, rst_n, commit, !out_valid_r || out_ready, "commit over unread result")
  `SWR_ASSERT_NEXT(a_commit_shows_result, clk, rst_n, commit, out_valid_r && in_ready, "commit gave no result")

endmodule

// ===== rtl/stack_with_remove_by_value.sv =====
// ----------------------------------------------------------------------------
// stack_with_remove_by_value
// Bounded LIFO of 16-bit identifiers with push and remove-topmost-copy.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Payload                         | Handshake
//  in_ch    | in  | opcode[0], car_id[15:0]         | valid/ready
//  out_ch   | out | status[1:0], entry_count[5:0]   | valid/ready
//
//  Each word is first accepted, which latches the per-cell compare, and
//  then committed: the push or the shift goes into the result register.
//  The next word is accepted in the cycle after the commit.
//  A stalled result holds the commit until the result register is free.
//  Reset (synchronous, active low) empties the store; no clearing pass.
// ----------------------------------------------------------------------------
module stack_with_remove_by_value #(
  parameter int DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  swr_in_if.sink          in_ch,
  swr_out_if.source       out_ch
);

  localparam int CW = $clog2(DEPTH + 1);

  swr_pkg::dp_cmd_t cmd;
  swr_pkg::dp_sts_t sts;
  logic [CW-1:0]    fill;

  // Sequencer
  swr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_opcode  (in_ch.opcode),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Entry cells and counter
  swr_datapath #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .car_id (in_ch.car_id),
    .sts    (sts),
    .fill   (fill)
  );

  // Count shown with the result; low bits only when the count is wider
  assign out_ch.entry_count = swr_pkg::COUNT_W'(fill);

endmodule

// ===== bench/stack_with_remove_by_value_test.sv =====
// ----------------------------------------------------------------------------
// stack_with_remove_by_value_test
// Self-checking bench for the identifier stack with remove-by-value. Command
// words go in through a valid/ready driver with random gaps. A shadow stack
// predicts the status and entry count of every accepted word. A monitor with
// random back-pressure compares each result word against the oldest pending
// prediction. Two long receiver hold-offs fill the block and stall its input.
// ----------------------------------------------------------------------------
module stack_with_remove_by_value_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic                     opcode;
    logic [swr_pkg::ID_W-1:0] car_id;
  } cmd_word_t;

  typedef struct packed {
    logic [swr_pkg::STATUS_W-1:0] status;
    logic [swr_pkg::COUNT_W-1:0]  entry_count;
  } result_word_t;

  logic clk;
  logic rst_n;

  swr_in_if  in_ch ();
  swr_out_if out_ch ();

  stack_with_remove_by_value #(
    .DEPTH(STACK_DEPTH)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow stack, index 0 is the bottom
  logic [swr_pkg::ID_W-1:0] stored_ids [STACK_DEPTH];
  int                       stored_count;

  cmd_word_t    pending_words [$];
  result_word_t due_results [$];
  int           error_count;
  int           cycle_count;
  logic         rx_hold_off;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one word to the shadow stack and return what the block must answer
  function automatic result_word_t apply_stack_word(cmd_word_t w);
    result_word_t r;
    int           pos;
    if (w.opcode == swr_pkg::OP_PUSH) begin
      if (stored_count >= STACK_DEPTH) begin
        r.status = swr_pkg::ST_FULL;
      end else begin
        stored_ids[stored_count] = w.car_id;
        stored_count++;
        r.status = swr_pkg::ST_DONE;
      end
    end else begin
      // search from the top for the nearest copy
      pos = stored_count - 1;
      while (pos >= 0 && stored_ids[pos] != w.car_id) pos--;
      if (pos < 0) begin
        r.status = swr_pkg::ST_NOT_FOUND;
      end else begin
        // close the gap, keep the order of the rest
        for (int k = pos; k < stored_count - 1; k++) stored_ids[k] = stored_ids[k + 1];
        stored_count--;
        r.status = swr_pkg::ST_DONE;
      end
    end
    r.entry_count = swr_pkg::COUNT_W'(stored_count);
    return r;
  endfunction

  // Gap length for the n-th word; every fourth stretch of 60 runs back to back
  function automatic int idle_draw(int n);
    if ((n / 60) % 4 == 3) return 0;
    return $urandom_range(0, 7);
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    error_count++;
  endtask

  // Driver: offers queued words, predicts each one as it is taken
  int        tx_wait;
  int        tx_index;
  cmd_word_t tx_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.opcode <= swr_pkg::OP_PUSH;
      in_ch.car_id <= '0;
      tx_wait = idle_draw(0);
      tx_index = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        due_results.push_back(apply_stack_word(tx_word));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          tx_word = pending_words.pop_front();
          in_ch.opcode <= tx_word.opcode;
          in_ch.car_id <= tx_word.car_id;
          in_ch.valid  <= 1'b1;
          tx_index++;
          tx_wait = idle_draw(tx_index);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random ready, field-by-field check against the oldest prediction
  int           rx_wait;
  int           rx_index;
  result_word_t rx_want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = idle_draw(0);
      rx_index = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected word, status", out_ch.status, -1);
        end else begin
          rx_want = due_results.pop_front();
          if (out_ch.status !== rx_want.status)
            report_mismatch("status", out_ch.status, rx_want.status);
          if (out_ch.entry_count !== rx_want.entry_count)
            report_mismatch("entry_count", out_ch.entry_count, rx_want.entry_count);
        end
        rx_index++;
        rx_wait = idle_draw(rx_index);
      end
      if (rx_hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-offs so the block backs up and stalls its input
  int hold_clock;
  int hold_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold_off <= 1'b0;
      hold_clock = 0;
      hold_left = 0;
    end else begin
      hold_clock++;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) rx_hold_off <= 1'b0;
      end else if (hold_clock == 500 || hold_clock == 2500) begin
        hold_left = HOLD_CYCLES;
        rx_hold_off <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus and end of run
  logic [swr_pkg::ID_W-1:0] id_pool [12];
  int                       push_bias [6];
  int                       push_pct;
  cmd_word_t                w;

  task automatic queue_word(logic op, logic [swr_pkg::ID_W-1:0] id);
    cmd_word_t c;
    c.opcode = op;
    c.car_id = id;
    pending_words.push_back(c);
  endtask

  initial begin
    rst_n        = 1'b0;
    error_count  = 0;
    cycle_count  = 0;
    stored_count = 0;
    id_pool   = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'h1234,
                  16'hA5A5, 16'h5A5A, 16'h00FF, 16'hFF00, 16'h0042, 16'hBEEF};
    push_bias = '{90, 95, 50, 10, 60, 5};

    // Directed: empty remove, extremes, duplicates, top/middle/bottom hits, misses
    queue_word(swr_pkg::OP_REMOVE, 16'h0005);
    queue_word(swr_pkg::OP_PUSH,   16'h0000);
    queue_word(swr_pkg::OP_PUSH,   16'hFFFF);
    queue_word(swr_pkg::OP_PUSH,   16'h1234);
    queue_word(swr_pkg::OP_PUSH,   16'h1234);
    queue_word(swr_pkg::OP_PUSH,   16'hA5A5);
    queue_word(swr_pkg::OP_REMOVE, 16'h1234);
    queue_word(swr_pkg::OP_REMOVE, 16'h0000);
    queue_word(swr_pkg::OP_REMOVE, 16'h5555);
    queue_word(swr_pkg::OP_REMOVE, 16'hA5A5);
    queue_word(swr_pkg::OP_REMOVE, 16'h1234);
    queue_word(swr_pkg::OP_REMOVE, 16'hFFFF);
    queue_word(swr_pkg::OP_REMOVE, 16'hFFFF);
    queue_word(swr_pkg::OP_PUSH,   16'h8000);
    queue_word(swr_pkg::OP_PUSH,   16'h7FFF);
    queue_word(swr_pkg::OP_PUSH,   16'h5555);
    queue_word(swr_pkg::OP_PUSH,   16'hAAAA);
    queue_word(swr_pkg::OP_REMOVE, 16'h7FFF);
    queue_word(swr_pkg::OP_REMOVE, 16'h8000);
    queue_word(swr_pkg::OP_REMOVE, 16'hAAAA);
    queue_word(swr_pkg::OP_REMOVE, 16'h5555);

    // Random: blocks with different push bias so the stack fills, refuses and drains
    for (int blk = 0; blk < 13; blk++) begin
      push_pct = push_bias[blk % 6];
      for (int k = 0; k < 50; k++) begin
        w.opcode = ($urandom_range(0, 99) < push_pct) ? swr_pkg::OP_PUSH
                                                       : swr_pkg::OP_REMOVE;
        if ($urandom_range(0, 3) == 0) w.car_id = swr_pkg::ID_W'($urandom());
        else w.car_id = id_pool[$urandom_range(0, 11)];
        pending_words.push_back(w);
      end
    end

    // Hold reset, then release it
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all words taken and all results seen
    @(posedge clk);
    while (pending_words.size() != 0 || in_ch.valid || due_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== stack_with_remove_by_value.f =====
+incdir+rtl
rtl/swr_pkg.sv
rtl/swr_in_if.sv
rtl/swr_out_if.sv
rtl/swr_datapath.sv
rtl/swr_ctrl.sv
rtl/stack_with_remove_by_value.sv
bench/stack_with_remove_by_value_test.sv
